// ===== sv/ucep_pkg.sv =====
package ucep_pkg;

  localparam int PKT_BYTES = 8;
  localparam int ROM_BYTES = 128;
  localparam int ROM_AW = $clog2(ROM_BYTES);
  localparam int CNT_W = $clog2(PKT_BYTES + 1);

  // Endpoint zero events
  localparam logic [1:0] CmdSetup    = 2'd0;
  localparam logic [1:0] CmdStatusOut = 2'd1;
  localparam logic [1:0] CmdInDone   = 2'd2;
  localparam logic [1:0] CmdBusReset = 2'd3;

  // Standard request codes
  localparam logic [7:0] ReqClearFeature = 8'd1;
  localparam logic [7:0] ReqSetAddress   = 8'd5;
  localparam logic [7:0] ReqGetDesc      = 8'd6;
  localparam logic [7:0] ReqSetConfig    = 8'd9;

  // Descriptor types
  localparam logic [7:0] DescDevice = 8'd1;
  localparam logic [7:0] DescConfig = 8'd2;
  localparam logic [7:0] DescString = 8'd3;

  // Request still being handled on endpoint zero
  localparam logic [2:0] PendNone   = 3'd0;
  localparam logic [2:0] PendClear  = 3'd1;
  localparam logic [2:0] PendAddr   = 3'd2;
  localparam logic [2:0] PendDesc   = 3'd3;
  localparam logic [2:0] PendConfig = 3'd4;
  localparam logic [2:0] PendDone   = 3'd5;

  // Device states
  localparam logic [1:0] DevPowered    = 2'd0;
  localparam logic [1:0] DevDefault    = 2'd1;
  localparam logic [1:0] DevAddressed  = 2'd2;
  localparam logic [1:0] DevConfigured = 2'd3;

  localparam logic [7:0] TypeClassMask  = 8'h60;
  localparam logic [7:0] TypeEndpoint   = 8'h02;
  localparam logic [7:0] Ep1InAddr      = 8'h81;
  localparam logic [7:0] Ep2OutAddr     = 8'h02;
  localparam logic [7:0] AddrHighBit    = 8'h80;

  localparam logic [7:0] OffDevice = 8'd0;
  localparam logic [7:0] OffConfig = 8'd18;
  localparam logic [7:0] OffConfigLen = 8'd20;

  localparam logic [7:0] DESC_ROM [ROM_BYTES] = '{
    // device
    8'd18, 8'd1, 8'h10, 8'h01, 8'd0, 8'd0, 8'd0, 8'd8, 8'h70, 8'h0c, 8'h00, 8'h00,
    8'h00, 8'h01, 8'd1, 8'd2, 8'd0, 8'd1,
    // configuration, interface, two endpoints
    8'd9, 8'd2, 8'd32, 8'd0, 8'd1, 8'd1, 8'd0, 8'hc0, 8'd0,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'hff, 8'h01, 8'hff, 8'd0,
    8'd7, 8'd5, 8'h81, 8'h03, 8'h08, 8'h00, 8'd10,
    8'd7, 8'd5, 8'h02, 8'h03, 8'h08, 8'h00, 8'd10,
    // string 0: language id
    8'd4, 8'd3, 8'h09, 8'h04,
    // string 1: manufacturer
    8'd46, 8'd3,
    8'h50, 8'd0, 8'h72, 8'd0, 8'h6f, 8'd0, 8'h63, 8'd0, 8'h65, 8'd0, 8'h64, 8'd0,
    8'h75, 8'd0, 8'h72, 8'd0, 8'h61, 8'd0, 8'h6c, 8'd0, 8'h57, 8'd0, 8'h6f, 8'd0,
    8'h72, 8'd0, 8'h6c, 8'd0, 8'h64, 8'd0, 8'h73, 8'd0, 8'h2e, 8'd0, 8'h63, 8'd0,
    8'h6f, 8'd0, 8'h2e, 8'd0, 8'h75, 8'd0, 8'h6b, 8'd0,
    // string 2: product
    8'd26, 8'd3,
    8'h55, 8'd0, 8'h53, 8'd0, 8'h42, 8'd0, 8'h54, 8'd0, 8'h65, 8'd0, 8'h73, 8'd0,
    8'h74, 8'd0, 8'h5f, 8'd0, 8'h30, 8'd0, 8'h30, 8'd0, 8'h30, 8'd0, 8'h30, 8'd0,
    // spare
    8'd0, 8'd0
  };

  function automatic logic [7:0] string_offset(input logic [1:0] idx);
    logic [7:0] off;
    case (idx)
      2'd0:    off = 8'd50;
      2'd1:    off = 8'd54;
      2'd2:    off = 8'd100;
      default: off = 8'd0;
    endcase
    return off;
  endfunction

  typedef struct packed {
    logic [1:0] cmd;
    logic       setup_ok;
    logic [7:0] request_type;
    logic [7:0] request_code;
    logic [7:0] value_low;
    logic [7:0] value_high;
    logic [7:0] index_low;
    logic [7:0] index_high;
    logic [7:0] length_low;
    logic [7:0] length_high;
  } in_item_t;

  typedef struct packed {
    logic        stall_res;
    logic        tx_enable;
    logic        tx_toggle;
    logic [3:0]  tx_count;
    logic [63:0] tx_bytes;
    logic [6:0]  device_address;
    logic [1:0]  device_state;
    logic        ep1_active;
    logic        ep2_active;
    logic        ep1_unstall;
    logic        ep2_unstall;
    logic        rx_enable;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic       set;
    logic [7:0] offset;
    logic [7:0] left;
  } ldr_ctrl_t;

  typedef struct packed {
    logic                      done;
    logic [CNT_W-1:0]          count;
    logic [PKT_BYTES*8-1:0]    data;
  } ldr_stat_t;

endpackage

// ===== sv/ucep_loader.sv =====
module ucep_loader (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ucep_pkg::ldr_ctrl_t  ctrl_i,
  output ucep_pkg::ldr_stat_t  stat_o
);

  logic                               running_q, running_d;
  logic [7:0]                         offset_q, offset_d;
  logic [7:0]                         left_q, left_d;
  logic [ucep_pkg::CNT_W-1:0]         count_q, count_d;
  logic [ucep_pkg::PKT_BYTES-1:0][7:0] data_q, data_d;
  logic                               step;
  logic [7:0]                         rom_byte;

  // One descriptor byte per cycle until the packet is full or the request runs out.
  assign step = running_q && (left_q != 8'd0) &&
                (count_q != ucep_pkg::CNT_W'(ucep_pkg::PKT_BYTES));
  assign rom_byte = ucep_pkg::DESC_ROM[offset_q[ucep_pkg::ROM_AW-1:0]];

  always_comb begin
    running_d = running_q;
    offset_d  = offset_q;
    left_d    = left_q;
    count_d   = count_q;
    data_d    = data_q;
    if (ctrl_i.start) begin
      running_d = 1'b1;
      count_d   = '0;
      data_d    = '0;
      if (ctrl_i.set) begin
        offset_d = ctrl_i.offset;
        left_d   = ctrl_i.left;
      end
    end else if (step) begin
      data_d[count_q[$clog2(ucep_pkg::PKT_BYTES)-1:0]] = rom_byte;
      offset_d = offset_q + 8'd1;
      left_d   = left_q - 8'd1;
      count_d  = count_q + ucep_pkg::CNT_W'(1);
    end else if (running_q) begin
      running_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      offset_q  <= '0;
      left_q    <= '0;
      count_q   <= '0;
    end else begin
      running_q <= running_d;
      offset_q  <= offset_d;
      left_q    <= left_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign stat_o.done  = running_q && !step;
  assign stat_o.count = count_q;
  assign stat_o.data  = data_q;

endmodule

// ===== sv/usb_control_endpoint_handler.sv =====
// Endpoint zero control engine: each event transfer (setup, status OUT, IN done, bus reset)
// yields exactly one result transfer holding the endpoint and device levels after the event.
// Events other than descriptor work pass from acceptance through the SOut state into the
// result register, and the next event can be taken once that result has been placed there.
// A GET_DESCRIPTOR setup, and every IN done while a descriptor is in flight, run the shared
// byte loader over the descriptor ROM, one byte per cycle, so those pass through the SLoad
// state until the loader has read the chunk of at most eight bytes, then through SOut into
// the result register. The input side stalls until the result has been placed in the output
// register; a result waiting there does not hold up acceptance of the next event, but that
// event's result then waits until the output side has taken the earlier one.
module usb_control_endpoint_handler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ucep_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ucep_pkg::out_item_t  out_data_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SLoad = 2'd1;
  localparam logic [1:0] SOut  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [1:0]  dev_state_q, dev_state_d;
  logic [6:0]  dev_addr_q, dev_addr_d;
  logic [2:0]  pend_q, pend_d;
  logic [7:0]  pend_addr_q, pend_addr_d;
  logic        toggle_q, toggle_d;
  logic        stall_q, stall_d;
  logic        tx_en_q, tx_en_d;
  logic [3:0]  tx_cnt_q, tx_cnt_d;
  logic [63:0] tx_data_q, tx_data_d;
  logic        rx_en_q, rx_en_d;
  logic        ep1_q, ep1_d;
  logic        ep2_q, ep2_d;
  logic        un1_q, un1_d;
  logic        un2_q, un2_d;
  logic        out_valid_q, out_valid_d;
  ucep_pkg::out_item_t out_data_q, out_data_d;

  ucep_pkg::ldr_ctrl_t ldr_ctrl;
  ucep_pkg::ldr_stat_t ldr_stat;

  logic       accept;
  logic       out_room;
  logic [7:0] desc_off;
  logic [7:0] desc_len;
  logic [7:0] desc_len_addr;
  logic       desc_ok;
  ucep_pkg::in_item_t it;

  ucep_loader u_loader (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ldr_ctrl),
    .stat_o (ldr_stat)
  );

  assign it         = in_data_i;
  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_room   = !out_valid_q || !out_stall_i;

  // Descriptor selection: the length byte of the configuration set sits at wTotalLength.
  always_comb begin
    desc_ok       = 1'b1;
    desc_off      = ucep_pkg::OffDevice;
    desc_len_addr = ucep_pkg::OffDevice;
    if (it.value_high == ucep_pkg::DescDevice) begin
      desc_off      = ucep_pkg::OffDevice;
      desc_len_addr = ucep_pkg::OffDevice;
    end else if (it.value_high == ucep_pkg::DescConfig) begin
      desc_off      = ucep_pkg::OffConfig;
      desc_len_addr = ucep_pkg::OffConfigLen;
    end else if (it.value_high == ucep_pkg::DescString && it.value_low <= 8'd2) begin
      desc_off      = ucep_pkg::string_offset(it.value_low[1:0]);
      desc_len_addr = desc_off;
    end else begin
      desc_ok = 1'b0;
    end
    desc_len = ucep_pkg::DESC_ROM[desc_len_addr[ucep_pkg::ROM_AW-1:0]];
    if (it.length_high == 8'd0 && it.length_low < desc_len) begin
      desc_len = it.length_low;
    end
  end

  always_comb begin
    state_d     = state_q;
    dev_state_d = dev_state_q;
    dev_addr_d  = dev_addr_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    toggle_d    = toggle_q;
    stall_d     = stall_q;
    tx_en_d     = tx_en_q;
    tx_cnt_d    = tx_cnt_q;
    tx_data_d   = tx_data_q;
    rx_en_d     = rx_en_q;
    ep1_d       = ep1_q;
    ep2_d       = ep2_q;
    un1_d       = un1_q;
    un2_d       = un2_q;
    ldr_ctrl    = '0;

    if (accept) begin
      state_d   = SOut;
      tx_en_d   = 1'b0;
      tx_cnt_d  = 4'd0;
      tx_data_d = 64'd0;
      un1_d     = 1'b0;
      un2_d     = 1'b0;
      case (it.cmd)
        ucep_pkg::CmdSetup: begin
          // A new setup aborts whatever transfer was in progress.
          stall_d = 1'b0;
          pend_d  = ucep_pkg::PendNone;
          rx_en_d = 1'b1;
          if (!it.setup_ok || (it.request_type & ucep_pkg::TypeClassMask) != 8'd0) begin
            stall_d = 1'b1;
          end else begin
            case (it.request_code)
              ucep_pkg::ReqClearFeature: begin
                if (it.value_high != 8'd0 || it.index_high != 8'd0 ||
                    it.length_high != 8'd0 || it.length_low != 8'd0) begin
                  stall_d = 1'b1;
                end else if (it.request_type == ucep_pkg::TypeEndpoint &&
                             it.value_low == 8'd0 &&
                             (it.index_low == ucep_pkg::Ep1InAddr ||
                              it.index_low == ucep_pkg::Ep2OutAddr)) begin
                  un1_d     = (it.index_low == ucep_pkg::Ep1InAddr);
                  un2_d     = (it.index_low != ucep_pkg::Ep1InAddr);
                  pend_d    = ucep_pkg::PendClear;
                  toggle_d  = 1'b1;
                  tx_en_d   = 1'b1;
                end else begin
                  stall_d = 1'b1;
                end
              end
              ucep_pkg::ReqSetAddress: begin
                if (it.index_high != 8'd0 || it.index_low != 8'd0 ||
                    it.length_high != 8'd0 || it.length_low != 8'd0 ||
                    it.value_high != 8'd0 ||
                    (it.value_low & ucep_pkg::AddrHighBit) != 8'd0) begin
                  stall_d = 1'b1;
                end else begin
                  pend_d      = ucep_pkg::PendAddr;
                  pend_addr_d = it.value_low;
                  toggle_d    = 1'b1;
                  tx_en_d     = 1'b1;
                end
              end
              ucep_pkg::ReqGetDesc: begin
                if (desc_ok) begin
                  pend_d          = ucep_pkg::PendDesc;
                  toggle_d        = 1'b1;
                  ldr_ctrl.start  = 1'b1;
                  ldr_ctrl.set    = 1'b1;
                  ldr_ctrl.offset = desc_off;
                  ldr_ctrl.left   = desc_len;
                  state_d         = SLoad;
                end else begin
                  stall_d = 1'b1;
                end
              end
              ucep_pkg::ReqSetConfig: begin
                if (it.index_high != 8'd0 || it.index_low != 8'd0 ||
                    it.length_high != 8'd0 || it.length_low != 8'd0 ||
                    it.value_high != 8'd0 || it.value_low > 8'd1 ||
                    dev_state_q == ucep_pkg::DevDefault) begin
                  stall_d = 1'b1;
                end else begin
                  if (it.value_low != 8'd0) begin
                    dev_state_d = ucep_pkg::DevConfigured;
                    ep1_d       = 1'b1;
                    ep2_d       = 1'b1;
                    un1_d       = 1'b1;
                    un2_d       = 1'b1;
                  end else begin
                    dev_state_d = ucep_pkg::DevAddressed;
                    ep1_d       = 1'b0;
                    ep2_d       = 1'b0;
                  end
                  pend_d   = ucep_pkg::PendConfig;
                  toggle_d = 1'b1;
                  tx_en_d  = 1'b1;
                end
              end
              default: begin
                stall_d = 1'b1;
              end
            endcase
          end
        end
        ucep_pkg::CmdStatusOut: begin
          rx_en_d = 1'b1;
        end
        ucep_pkg::CmdInDone: begin
          case (pend_q)
            ucep_pkg::PendAddr: begin
              // The new address only takes effect once the status stage has gone out.
              dev_addr_d  = pend_addr_q[6:0];
              dev_state_d = (pend_addr_q != 8'd0) ? ucep_pkg::DevAddressed
                                                   : ucep_pkg::DevDefault;
              pend_d      = ucep_pkg::PendDone;
            end
            ucep_pkg::PendDesc: begin
              toggle_d       = !toggle_q;
              rx_en_d        = 1'b1;
              ldr_ctrl.start = 1'b1;
              state_d        = SLoad;
            end
            ucep_pkg::PendClear, ucep_pkg::PendConfig: begin
              pend_d = ucep_pkg::PendDone;
            end
            ucep_pkg::PendDone: begin
              pend_d = pend_q;
            end
            default: begin
              stall_d = 1'b1;
              pend_d  = ucep_pkg::PendNone;
            end
          endcase
        end
        default: begin
          dev_addr_d  = 7'd0;
          dev_state_d = ucep_pkg::DevDefault;
          toggle_d    = 1'b0;
          rx_en_d     = 1'b1;
          stall_d     = 1'b0;
          ep1_d       = 1'b0;
          ep2_d       = 1'b0;
          pend_d      = ucep_pkg::PendNone;
        end
      endcase
    end else if (state_q == SLoad && ldr_stat.done) begin
      tx_en_d   = 1'b1;
      tx_cnt_d  = ldr_stat.count;
      tx_data_d = ldr_stat.data;
      // A short packet, including a zero-length one, ends the data stage.
      if (ldr_stat.count != 4'(ucep_pkg::PKT_BYTES)) begin
        pend_d = ucep_pkg::PendDone;
      end
      state_d = SOut;
    end else if (state_q == SOut && out_room) begin
      state_d = SIdle;
    end
  end

  always_comb begin
    out_data_d                = out_data_q;
    out_valid_d               = out_valid_q && out_stall_i;
    if (state_q == SOut && out_room) begin
      out_valid_d                = 1'b1;
      out_data_d.stall_res       = stall_q;
      out_data_d.tx_enable       = tx_en_q;
      out_data_d.tx_toggle       = toggle_q;
      out_data_d.tx_count        = tx_en_q ? tx_cnt_q : 4'd0;
      out_data_d.tx_bytes        = tx_en_q ? tx_data_q : 64'd0;
      out_data_d.device_address  = dev_addr_q;
      out_data_d.device_state    = dev_state_q;
      out_data_d.ep1_active      = ep1_q;
      out_data_d.ep2_active      = ep2_q;
      out_data_d.ep1_unstall     = un1_q;
      out_data_d.ep2_unstall     = un2_q;
      out_data_d.rx_enable       = rx_en_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      dev_state_q <= ucep_pkg::DevPowered;
      dev_addr_q  <= 7'd0;
      pend_q      <= ucep_pkg::PendNone;
      pend_addr_q <= 8'd0;
      toggle_q    <= 1'b0;
      stall_q     <= 1'b0;
      tx_en_q     <= 1'b0;
      tx_cnt_q    <= 4'd0;
      rx_en_q     <= 1'b0;
      ep1_q       <= 1'b0;
      ep2_q       <= 1'b0;
      un1_q       <= 1'b0;
      un2_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dev_state_q <= dev_state_d;
      dev_addr_q  <= dev_addr_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
      toggle_q    <= toggle_d;
      stall_q     <= stall_d;
      tx_en_q     <= tx_en_d;
      tx_cnt_q    <= tx_cnt_d;
      rx_en_q     <= rx_en_d;
      ep1_q       <= ep1_d;
      ep2_q       <= ep2_d;
      un1_q       <= un1_d;
      un2_q       <= un2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_data_q  <= tx_data_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
